[design/ptt_pkg.sv]
// ---------------------------------------------------------------------------
// ptt_pkg: shared types and constants of the periodic/one-shot timer table
// Holds the request and result payloads, operation and status codes, the
// controller state encoding and the controller/datapath interface structs.
// ---------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

  // Fixed field widths of the payloads
  localparam int SLOT_W   = 4;
  localparam int PERIOD_W = 32;
  localparam int TAG_W    = 16;
  localparam int INC_W    = 16;

  // Configuration port
  localparam int                CFG_AW         = 3;
  localparam int                CFG_DW         = 32;
  localparam logic [0:0]        REG_TICK_INC   = 1'b0;
  localparam logic [INC_W-1:0]  TICK_INC_RESET = 16'd100;

  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_DEL  = 2'd1,
    FUNC_TICK = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    TTYPE_RT_ONESHOT    = 2'd0,
    TTYPE_DELAY_ONESHOT = 2'd1,
    TTYPE_PERIODIC      = 2'd2
  } ttype_t;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_FIRE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_TYPE  = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]          func;
    logic [1:0]          timer_type;
    logic [PERIOD_W-1:0] period;
    logic [SLOT_W-1:0]   handle;
    logic [TAG_W-1:0]    tag;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        fired_type;
    logic [TAG_W-1:0]  fired_tag;
    logic              last;
  } out_rsp_t;

  // One timer entry as held in the slot memory
  typedef struct packed {
    logic [1:0]          timer_type;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] elapsed;
    logic [TAG_W-1:0]    tag;
  } slot_ent_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_ADD   = 3'd1,
    S_DEL   = 3'd2,
    S_TICK  = 3'd3,
    S_DRAIN = 3'd4,
    S_FLUSH = 3'd5
  } state_t;

  typedef struct packed {
    logic load;      // latch request, clear scan counters
    logic add_step;  // advance free-slot search
    logic add_ok;    // store timer at search index, answer ok
    logic add_bad;   // answer invalid type
    logic add_full;  // answer table full
    logic del;       // perform delete and answer
    logic tick_rd;   // issue slot read, advance slot/type counters
    logic flush;     // emit held fire result as the last one
  } ctrl_cmd_t;

  typedef struct packed {
    logic type_bad;
    logic cur_free;
    logic idx_last;
    logic pass_last;
  } dp_stat_t;

endpackage

`default_nettype wire

[design/ptt_ram.sv]
// ---------------------------------------------------------------------------
// ptt_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data. No reset.
// ---------------------------------------------------------------------------
`default_nettype none

module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[design/ptt_ctrl.sv]
// ---------------------------------------------------------------------------
// ptt_ctrl: request sequencer of the timer table
// Decodes each request and steps the datapath through add search, delete,
// or the tick scan over all types and slots.
// ---------------------------------------------------------------------------
`default_nettype none

module ptt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [1:0]          in_func,
  input  wire ptt_pkg::dp_stat_t   stat,
  output      logic                busy,
  output      ptt_pkg::ctrl_cmd_t  cmd
);
  import ptt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          unique case (in_func)
            FUNC_ADD:  state_nxt = S_ADD;
            FUNC_DEL:  state_nxt = S_DEL;
            FUNC_TICK: state_nxt = S_TICK;
            default:   state_nxt = S_IDLE;  // unused code: drop
          endcase
        end
      end
      S_ADD: begin
        if (stat.type_bad) begin
          cmd.add_bad = 1'b1;
          state_nxt   = S_IDLE;
        end else if (stat.cur_free) begin
          cmd.add_ok = 1'b1;
          state_nxt  = S_IDLE;
        end else if (stat.idx_last) begin
          cmd.add_full = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.add_step = 1'b1;
        end
      end
      S_DEL: begin
        cmd.del   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_TICK: begin
        cmd.tick_rd = 1'b1;
        if (stat.idx_last && stat.pass_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/ptt_dp.sv]
// ---------------------------------------------------------------------------
// ptt_dp: datapath of the timer table
// Valid bits, slot memory, scan counters, saturating count update with
// fire compare, one-deep hold of fire results and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module ptt_dp #(
  parameter int SLOTS = 16,
  parameter int TYPES = 3
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ptt_pkg::in_req_t    in_req,
  input  wire logic [15:0]         tick_inc,
  input  wire ptt_pkg::ctrl_cmd_t  cmd,
  output      ptt_pkg::dp_stat_t   stat,
  output      logic                out_strobe,
  output      ptt_pkg::out_rsp_t   out_rsp
);
  import ptt_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int TW = $clog2(TYPES);
  localparam int EW = $bits(slot_ent_t);

  in_req_t          req_r;
  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] valid_nxt;
  logic [SW-1:0]    idx_r;
  logic [SW-1:0]    idx_nxt;
  logic [TW-1:0]    pass_r;
  logic [TW-1:0]    pass_nxt;
  logic             rd_v_r;
  logic [SW-1:0]    idx_d_r;
  logic [TW-1:0]    pass_d_r;
  out_rsp_t         pend_r;
  out_rsp_t         pend_nxt;
  logic             pend_v_r;
  logic             pend_v_nxt;
  out_rsp_t         out_r;
  out_rsp_t         out_nxt;
  logic             out_v_r;
  logic             out_v_nxt;

  logic             ram_we;
  logic [SW-1:0]    ram_waddr;
  slot_ent_t        ram_wdata;
  logic [EW-1:0]    ram_rdata;
  slot_ent_t        ent;

  logic [PERIOD_W:0]   sum;
  logic [PERIOD_W-1:0] sat;
  logic                hit;
  logic                fire;
  logic                one_shot;
  logic [SW-1:0]       hidx;
  logic                del_ok;
  out_rsp_t            fire_rsp;

  ptt_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Status to controller
  always_comb begin
    stat.type_bad  = 32'(req_r.timer_type) >= TYPES;
    stat.cur_free  = !valid_r[idx_r];
    stat.idx_last  = idx_r == SW'(SLOTS - 1);
    stat.pass_last = pass_r == TW'(TYPES - 1);
  end

  // Count update and fire decision for the slot read in the previous cycle
  always_comb begin
    ent      = ram_rdata;
    sum      = {1'b0, ent.elapsed} + {{(PERIOD_W + 1 - INC_W){1'b0}}, tick_inc};
    sat      = sum[PERIOD_W] ? {PERIOD_W{1'b1}} : sum[PERIOD_W-1:0];
    hit      = rd_v_r && valid_r[idx_d_r] && (ent.timer_type == 2'(pass_d_r));
    fire     = hit && (sat >= ent.period);
    one_shot = (ent.timer_type == TTYPE_RT_ONESHOT) ||
               (ent.timer_type == TTYPE_DELAY_ONESHOT);
    hidx     = SW'(req_r.handle);
    del_ok   = (32'(req_r.handle) < SLOTS) && valid_r[hidx];

    fire_rsp            = '0;
    fire_rsp.kind       = KIND_FIRE;
    fire_rsp.status     = ST_OK;
    fire_rsp.slot       = SLOT_W'(idx_d_r);
    fire_rsp.fired_type = ent.timer_type;
    fire_rsp.fired_tag  = ent.tag;
    fire_rsp.last       = 1'b0;
  end

  // Slot memory write: new timer on add, updated count on tick
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ent;
    if (cmd.add_ok) begin
      ram_we               = 1'b1;
      ram_wdata.timer_type = req_r.timer_type;
      ram_wdata.period     = req_r.period;
      ram_wdata.elapsed    = '0;
      ram_wdata.tag        = req_r.tag;
    end else if (hit) begin
      ram_we            = 1'b1;
      ram_waddr         = idx_d_r;
      ram_wdata.elapsed = fire ? '0 : sat;
    end
  end

  // Valid bits and scan counters
  always_comb begin
    valid_nxt = valid_r;
    if (cmd.add_ok) begin
      valid_nxt[idx_r] = 1'b1;
    end
    if (cmd.del && del_ok) begin
      valid_nxt[hidx] = 1'b0;
    end
    if (fire && one_shot) begin
      valid_nxt[idx_d_r] = 1'b0;
    end

    idx_nxt  = idx_r;
    pass_nxt = pass_r;
    if (cmd.load) begin
      idx_nxt  = '0;
      pass_nxt = '0;
    end else if (cmd.add_step) begin
      idx_nxt = idx_r + SW'(1);
    end else if (cmd.tick_rd) begin
      if (stat.idx_last) begin
        idx_nxt  = '0;
        pass_nxt = pass_r + TW'(1);
      end else begin
        idx_nxt = idx_r + SW'(1);
      end
    end
  end

  // Results: one fire is held back so the final one can carry last
  always_comb begin
    out_nxt    = out_r;
    out_v_nxt  = 1'b0;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;

    if (cmd.load) begin
      pend_v_nxt = 1'b0;
    end

    if (cmd.add_bad || cmd.add_ok || cmd.add_full || cmd.del) begin
      out_v_nxt = 1'b1;
      out_nxt   = '0;
      out_nxt.last = 1'b1;
      if (cmd.del) begin
        out_nxt.kind   = KIND_DEL;
        out_nxt.status = del_ok ? ST_OK : ST_NOT_FOUND;
        out_nxt.slot   = req_r.handle;
      end else begin
        out_nxt.kind = KIND_ADD;
        if (cmd.add_bad) begin
          out_nxt.status = ST_BAD_TYPE;
        end else if (cmd.add_full) begin
          out_nxt.status = ST_FULL;
        end else begin
          out_nxt.status = ST_OK;
          out_nxt.slot   = SLOT_W'(idx_r);
        end
      end
    end

    if (fire) begin
      if (pend_v_r) begin
        out_nxt   = pend_r;
        out_v_nxt = 1'b1;
      end
      pend_nxt   = fire_rsp;
      pend_v_nxt = 1'b1;
    end

    if (cmd.flush && pend_v_r) begin
      out_nxt      = pend_r;
      out_nxt.last = 1'b1;
      out_v_nxt    = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      idx_r    <= '0;
      pass_r   <= '0;
      rd_v_r   <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      idx_r    <= idx_nxt;
      pass_r   <= pass_nxt;
      rd_v_r   <= cmd.tick_rd;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    idx_d_r  <= idx_r;
    pass_d_r <= pass_r;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  assign out_strobe = out_v_r;
  assign out_rsp    = out_r;

endmodule

`default_nettype wire

[design/periodic_oneshot_timer_table_core.sv]
// ---------------------------------------------------------------------------
// periodic_oneshot_timer_table_core: table of one-shot and periodic timers
// Top level: configuration register port, request sequencer and datapath.
// ---------------------------------------------------------------------------
// Usage
//   Request channel: a request is taken at a clock edge with start high and
//   busy low. in_req.func selects add (store a timer in the lowest free slot),
//   delete (free in_req.handle) or tick (advance every timer). An unused func
//   code is taken and dropped with no result.
//   Result channel: every result is shown on out_rsp for exactly one cycle
//   with out_strobe high; the receiver cannot hold results off. last marks
//   the final result of a request. A tick in which no timer fires gives none.
//   Operation
//     add    : free slots are searched one per cycle, valid bits read at the
//              search index.
//     tick   : the slot memory is read one slot per cycle, once per timer
//              type, so timers fire in type order and then slot order; a
//              fire result leaves one fire later, or at the end of the scan
//              as the last result.
//   Configuration: tick_increment at byte address 0 on the APB-style port.
//   Write it only while busy is low; the block itself does not enforce this.
//   Reset: value 100, every slot freed at once, ready the cycle after release.
// ---------------------------------------------------------------------------
`default_nettype none

module periodic_oneshot_timer_table_core #(
  parameter int SLOTS = 16,
  parameter int TYPES = 3
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // request channel
  input  wire logic                         start,
  output      logic                         busy,
  input  wire ptt_pkg::in_req_t             in_req,
  // result channel
  output      logic                         out_strobe,
  output      ptt_pkg::out_rsp_t            out_rsp,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ptt_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [ptt_pkg::CFG_DW-1:0]   pwdata,
  output      logic [ptt_pkg::CFG_DW-1:0]   prdata,
  output      logic                         pready
);
  import ptt_pkg::*;

  logic [INC_W-1:0] tick_inc_r;
  logic [INC_W-1:0] tick_inc_nxt;
  logic             reg_sel;
  logic             cfg_wr;
  ctrl_cmd_t        cmd;
  dp_stat_t         stat;

  // Register decode by word index; byte offset bits are ignored
  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == REG_TICK_INC;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    tick_inc_nxt = tick_inc_r;
    if (cfg_wr && reg_sel) begin
      tick_inc_nxt = pwdata[INC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_inc_r <= TICK_INC_RESET;
    end else begin
      tick_inc_r <= tick_inc_nxt;
    end
  end

  // Read back the increment; other word addresses read as zero
  assign prdata = reg_sel ? CFG_DW'(tick_inc_r) : '0;

  // Sequencer: decodes requests and steps the datapath
  ptt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_req.func),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  // Datapath: slot storage, count update, result register
  ptt_dp #(
    .SLOTS (SLOTS),
    .TYPES (TYPES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .tick_inc   (tick_inc_r),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp)
  );

endmodule

`default_nettype wire

[tb/sv/periodic_oneshot_timer_table_core_test.sv]
// ---------------------------------------------------------------------------
// periodic_oneshot_timer_table_core_test: self-checking bench of the timer table
// Drives add, delete and tick requests through the start/busy channel, writes
// tick_increment over the APB-style port between phases, and compares every
// strobed result against a table tracker that replays each accepted request.
// ---------------------------------------------------------------------------
module periodic_oneshot_timer_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ptt_pkg::*;

  localparam int SLOT_COUNT   = 16;
  localparam int TIMER_TYPES  = 3;
  // A full tick scan plus some margin; long enough for a silent tick to end.
  localparam int SCAN_CYCLES  = TIMER_TYPES * SLOT_COUNT + 3 + 8;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int ITEMS_PER_PHASE = 86;
  localparam int MAX_REPORTS  = 40;

  // Codes the package leaves unnamed: the spare func value and the bad type.
  localparam logic [1:0] FUNC_UNUSED   = 2'd3;
  localparam logic [1:0] TTYPE_INVALID = 2'd3;

  // -------------------------------------------------------------------------
  // Table tracker: mirrors slot state and queues the results each request owes
  // -------------------------------------------------------------------------
  class timer_table_tracker;
    logic [INC_W-1:0]    increment;
    bit                  slot_live  [SLOT_COUNT];
    ttype_t              slot_kind  [SLOT_COUNT];
    logic [PERIOD_W-1:0] slot_limit [SLOT_COUNT];
    logic [PERIOD_W-1:0] slot_count [SLOT_COUNT];
    logic [TAG_W-1:0]    slot_tag   [SLOT_COUNT];
    out_rsp_t            owed_results [$];
    int errors, compared, fires, full_answers, adds, deletes, ticks;

    function new();
      increment = TICK_INC_RESET;
      foreach (slot_live[i]) slot_live[i] = 1'b0;
    endfunction

    function out_rsp_t make_rsp(kind_t k, status_t s, logic [SLOT_W-1:0] slot,
                                logic [1:0] ftype, logic [TAG_W-1:0] ftag, logic last);
      out_rsp_t r;
      r.kind       = k;
      r.status     = s;
      r.slot       = slot;
      r.fired_type = ftype;
      r.fired_tag  = ftag;
      r.last       = last;
      return r;
    endfunction

    // Apply one accepted request and queue what it must produce.
    function void take_request(in_req_t r);
      int i;
      int t;
      int free_slot;
      int owed_before;
      logic [PERIOD_W:0] sum;
      case (r.func)
        FUNC_ADD: begin
          adds++;
          free_slot = -1;
          for (i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!slot_live[i]) free_slot = i;
          end
          // type check comes ahead of the full check
          if (r.timer_type > TTYPE_PERIODIC) begin
            owed_results.push_back(make_rsp(KIND_ADD, ST_BAD_TYPE, '0, '0, '0, 1'b1));
          end else if (free_slot < 0) begin
            full_answers++;
            owed_results.push_back(make_rsp(KIND_ADD, ST_FULL, '0, '0, '0, 1'b1));
          end else begin
            slot_live[free_slot]  = 1'b1;
            slot_kind[free_slot]  = ttype_t'(r.timer_type);
            slot_limit[free_slot] = r.period;
            slot_count[free_slot] = '0;
            slot_tag[free_slot]   = r.tag;
            owed_results.push_back(make_rsp(KIND_ADD, ST_OK, SLOT_W'(free_slot),
                                            '0, '0, 1'b1));
          end
        end
        FUNC_DEL: begin
          deletes++;
          if (slot_live[r.handle]) begin
            slot_live[r.handle] = 1'b0;
            owed_results.push_back(make_rsp(KIND_DEL, ST_OK, r.handle, '0, '0, 1'b1));
          end else begin
            owed_results.push_back(make_rsp(KIND_DEL, ST_NOT_FOUND, r.handle,
                                            '0, '0, 1'b1));
          end
        end
        FUNC_TICK: begin
          ticks++;
          owed_before = owed_results.size();
          // walk type by type, slots ascending within a type
          for (t = 0; t < TIMER_TYPES; t++) begin
            for (i = 0; i < SLOT_COUNT; i++) begin
              if (slot_live[i] && slot_kind[i] == ttype_t'(t)) begin
                sum = {1'b0, slot_count[i]} + increment;
                slot_count[i] = sum[PERIOD_W] ? '1 : sum[PERIOD_W-1:0];
                if (slot_count[i] >= slot_limit[i]) begin
                  owed_results.push_back(make_rsp(KIND_FIRE, ST_OK, SLOT_W'(i),
                                                  2'(t), slot_tag[i], 1'b0));
                  slot_count[i] = '0;
                  // one-shots drop out once they fire
                  if (ttype_t'(t) != TTYPE_PERIODIC) slot_live[i] = 1'b0;
                end
              end
            end
          end
          if (owed_results.size() > owed_before) owed_results[$].last = 1'b1;
        end
        default: ; // spare func code: dropped without a result
      endcase
    endfunction

    function void check_result(out_rsp_t got);
      out_rsp_t want;
      string    diff;
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with nothing pending: kind=%0d status=%0d slot=%0d",
                   $time, got.kind, got.status, got.slot);
        return;
      end
      want = owed_results.pop_front();
      compared++;
      if (want.kind == KIND_FIRE) fires++;
      diff = "";
      if (got.kind       !== want.kind)       diff = {diff, " kind"};
      if (got.status     !== want.status)     diff = {diff, " status"};
      if (got.slot       !== want.slot)       diff = {diff, " slot"};
      if (got.fired_type !== want.fired_type) diff = {diff, " fired_type"};
      if (got.fired_tag  !== want.fired_tag)  diff = {diff, " fired_tag"};
      if (got.last       !== want.last)       diff = {diff, " last"};
      if (diff != "") begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: mismatch on%s", $time, diff);
          $display("  expected kind=%0d status=%0d slot=%0d type=%0d tag=%h last=%0d",
                   want.kind, want.status, want.slot, want.fired_type,
                   want.fired_tag, want.last);
          $display("  actual   kind=%0d status=%0d slot=%0d type=%0d tag=%h last=%0d",
                   got.kind, got.status, got.slot, got.fired_type,
                   got.fired_tag, got.last);
        end
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, DUT and signals; every input starts at a known value
  // -------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic     start  = 1'b0;
  logic     busy;
  in_req_t  in_req = '0;
  logic     out_strobe;
  out_rsp_t out_rsp;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [CFG_DW-1:0] pwdata  = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  timer_table_tracker tracker;
  int  cycle_count = 0;
  bit  calm        = 1'b0;  // set for the final phase: no sender gaps
  int  settings    = 1;     // increment values used, reset value included

  always #10 clk = ~clk;

  periodic_oneshot_timer_table_core #(
    .SLOTS(SLOT_COUNT),
    .TYPES(TIMER_TYPES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_rsp   (out_rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Sample both channels at the rising edge. Check the result first, then
  // record a request taken at the same edge; its results can only come later.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe === 1'b1) tracker.check_result(out_rsp);
      if (start === 1'b1 && busy === 1'b0) tracker.take_request(in_req);
    end
  end

  // Watchdog: give up well past the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still owed", $time,
               tracker.owed_results.size());
      $display("periodic_oneshot_timer_table_core_test: errors");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Driving tasks; each one starts and ends just after a falling edge
  // -------------------------------------------------------------------------
  function automatic in_req_t make_req(logic [1:0] f, logic [1:0] tt,
                                       logic [PERIOD_W-1:0] period,
                                       logic [SLOT_W-1:0] handle, logic [TAG_W-1:0] tag);
    in_req_t r;
    r.func       = f;
    r.timer_type = tt;
    r.period     = period;
    r.handle     = handle;
    r.tag        = tag;
    return r;
  endfunction

  // Present a request and hold it until the block takes it. busy only moves
  // at rising edges, so its value here is what the next edge will see.
  task automatic send_request(input in_req_t r);
    start  <= 1'b1;
    in_req <= r;
    while (busy !== 1'b0) @(negedge clk);
    @(negedge clk);
    // random sender gap, skipped in the calm phase
    if (!calm && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  // Wait until every owed result is in and any silent tick has finished.
  task automatic settle();
    start <= 1'b0;
    while (tracker.owed_results.size() != 0) @(negedge clk);
    repeat (SCAN_CYCLES) @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
  endtask

  // Write tick_increment, then read it back.
  task automatic write_increment(input logic [INC_W-1:0] value);
    logic [CFG_DW-1:0] seen;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_TICK_INC, 2'b00};
    pwdata  <= CFG_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    tracker.increment = value;
    settings++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    seen = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (seen !== CFG_DW'(value)) begin
      tracker.errors++;
      $display("%0t: tick_increment readback: expected %h actual %h", $time,
               CFG_DW'(value), seen);
    end
  endtask

  // Build one random request. Adds, deletes and ticks dominate; a few carry
  // a bad type or the spare func code. Periods mostly land near a few ticks
  // so timers really fire, with zero and full-range values mixed in.
  function automatic in_req_t random_request(int add_weight);
    in_req_t r;
    int      roll;
    r.period = $urandom;
    r.handle = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
    r.tag    = TAG_W'($urandom_range(0, 16'hFFFF));
    r.timer_type = ($urandom_range(0, 9) == 0) ? TTYPE_INVALID
                                               : 2'($urandom_range(0, 2));
    case ($urandom_range(0, 3))
      0:       r.period = '0;
      1:       ;
      default: r.period = $urandom_range(0, 8 * int'(tracker.increment) + 1);
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 3)                     r.func = FUNC_UNUSED;
    else if (roll < 3 + add_weight)   r.func = FUNC_ADD;
    else if (roll < 23 + add_weight)  r.func = FUNC_DEL;
    else                              r.func = FUNC_TICK;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    in_req_t r;
    int      phase;
    int      sent;
    int      add_weight;
    logic [INC_W-1:0] next_inc;

    tracker = new();

    // hold reset, then release it on a falling edge
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset increment of 100.
    // Tick an empty table and send the spare func code: neither answers.
    send_request(make_req(FUNC_TICK, TTYPE_RT_ONESHOT, '0, '0, '0));
    send_request(make_req(FUNC_UNUSED, TTYPE_PERIODIC, '1, 4'hF, 16'hFFFF));
    // bad type loses even on an empty table; delete of the top handle misses
    send_request(make_req(FUNC_ADD, TTYPE_INVALID, 32'd50, '0, 16'h1111));
    send_request(make_req(FUNC_DEL, TTYPE_RT_ONESHOT, '0, 4'hF, '0));
    // fill slots 0..4 with every type and the period extremes
    send_request(make_req(FUNC_ADD, TTYPE_RT_ONESHOT, '0, '0, 16'hFFFF));
    send_request(make_req(FUNC_ADD, TTYPE_DELAY_ONESHOT, '1, '0, '0));
    send_request(make_req(FUNC_ADD, TTYPE_PERIODIC, '0, '0, 16'hA5A5));
    send_request(make_req(FUNC_ADD, TTYPE_PERIODIC, 32'd200, '0, 16'h5A5A));
    send_request(make_req(FUNC_ADD, TTYPE_DELAY_ONESHOT, 32'd100, '0, 16'h1234));
    // first tick fires one of each type; second fires both periodics
    send_request(make_req(FUNC_TICK, TTYPE_INVALID, '1, 4'hF, 16'hFFFF));
    send_request(make_req(FUNC_TICK, TTYPE_RT_ONESHOT, '0, '0, '0));
    // delete a live slot, then the same slot again
    send_request(make_req(FUNC_DEL, TTYPE_INVALID, '1, 4'd1, 16'hFFFF));
    send_request(make_req(FUNC_DEL, TTYPE_RT_ONESHOT, '0, 4'd1, '0));
    // add with unused fields all ones; first free slot is slot 0 again
    send_request(make_req(FUNC_ADD, TTYPE_PERIODIC, '1, 4'hF, 16'hFFFF));
    send_request(make_req(FUNC_TICK, TTYPE_RT_ONESHOT, '0, '0, '0));
    settle();

    // Random phases, each under its own increment: zero (only zero periods
    // fire and the table fills up), the maximum, a random one, the minimum
    // nonzero, and a random one with no sender gaps at all.
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       next_inc = '0;
        1:       next_inc = '1;
        3:       next_inc = 16'd1;
        default: next_inc = INC_W'($urandom_range(2, 16'hFFFE));
      endcase
      write_increment(next_inc);
      add_weight = (phase == 2) ? 60 : 40;
      calm = (phase == 4);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        r = random_request(add_weight);
        send_request(r);
        if (r.func != FUNC_UNUSED) sent++;
      end
      settle();
    end

    $display("Covered %0d adds, %0d deletes and %0d ticks under %0d increment values.",
             tracker.adds, tracker.deletes, tracker.ticks, settings);
    $display("Compared %0d results: %0d timer fires, %0d table-full answers.",
             tracker.compared, tracker.fires, tracker.full_answers);
    if (tracker.errors == 0) begin
      $display("periodic_oneshot_timer_table_core_test: clean");
    end else begin
      $display("%0d failures", tracker.errors);
      $display("periodic_oneshot_timer_table_core_test: errors");
    end
    $finish;
  end

endmodule
